// File: sv/uart16_pkg.sv
// Shared types, register codes and helper functions for the 16550-style UART register block.
// No dependencies; used by every module of the block.
package uart16_pkg;

   // Receive FIFO geometry (a power of two, so wrap-around is a mask).
   localparam int RX_FIFO_DEPTH = 16;
   localparam int RX_PTR_W      = $clog2(RX_FIFO_DEPTH);
   localparam int RX_CNT_W      = $clog2(RX_FIFO_DEPTH + 1);

   // Divisor used in the timeout reload when the latch holds zero.
   localparam int BAUD_BASE         = 115200;
   localparam int ZERO_DIVISOR_BAUD = 3500;
   localparam logic [15:0] ZERO_DIVISOR = 16'(BAUD_BASE / ZERO_DIVISOR_BAUD);

   localparam int TIMEOUT_W = 22;

   typedef logic [RX_PTR_W-1:0] rx_ptr_type;
   typedef logic [RX_CNT_W-1:0] rx_cnt_type;

   // Item functions.
   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_RXB   = 2'd2;
   localparam logic [1:0] FUNC_TICK  = 2'd3;

   // Register offsets.
   localparam logic [2:0] OFF_RBR = 3'd0;
   localparam logic [2:0] OFF_IER = 3'd1;
   localparam logic [2:0] OFF_IIR = 3'd2;
   localparam logic [2:0] OFF_LCR = 3'd3;
   localparam logic [2:0] OFF_MCR = 3'd4;
   localparam logic [2:0] OFF_LSR = 3'd5;
   localparam logic [2:0] OFF_MSR = 3'd6;
   localparam logic [2:0] OFF_SCR = 3'd7;

   // Interrupt identification codes.
   localparam logic [3:0] IID_MODEM   = 4'h0;
   localparam logic [3:0] IID_NONE    = 4'h1;
   localparam logic [3:0] IID_THRE    = 4'h2;
   localparam logic [3:0] IID_RXDATA  = 4'h4;
   localparam logic [3:0] IID_LINE    = 4'h6;
   localparam logic [3:0] IID_TIMEOUT = 4'hC;

   localparam logic [7:0] FCR_MASK = 8'hC9;

   // Prioritised interrupt identification; the upper nibble is kept.
   function automatic logic [7:0] irq_ident(
      input logic [7:0] iir,
      input logic [3:0] ier,
      input logic [7:0] lsr,
      input logic       tmo_pend,
      input logic       fifo_on,
      input rx_cnt_type cnt,
      input logic [3:0] trig,
      input logic       thr_pend,
      input logic [7:0] msr
   );
      logic [3:0] id;
      id = IID_NONE;
      if (ier[2] && (|lsr[4:1])) begin
         id = IID_LINE;
      end else if (ier[0] && tmo_pend) begin
         id = IID_TIMEOUT;
      end else if (ier[0] && lsr[0] && (!fifo_on || cnt >= rx_cnt_type'(trig))) begin
         id = IID_RXDATA;
      end else if (ier[1] && thr_pend) begin
         id = IID_THRE;
      end else if (ier[3] && (|msr[3:0])) begin
         id = IID_MODEM;
      end
      return {iir[7:4], id};
   endfunction

   // Timeout reload: four frames of divisor ticks.
   function automatic logic [TIMEOUT_W-1:0] timeout_reload(
      input logic [7:0]  lcr,
      input logic [15:0] dl
   );
      logic [3:0]  bits;
      logic [15:0] div;
      logic [19:0] prod;
      bits = 4'd6 + {3'd0, lcr[3]} + {2'd0, lcr[1:0]} + (lcr[2] ? 4'd2 : 4'd1);
      div  = (dl == 16'd0) ? ZERO_DIVISOR : dl;
      prod = 20'(bits) * 20'(div);
      return {prod, 2'b00};
   endfunction

   // Receive trigger level from FCR bits 7:6.
   function automatic logic [3:0] trigger_level(input logic [1:0] sel);
      logic [3:0] lvl;
      case (sel)
         2'd0:    lvl = 4'd1;
         2'd1:    lvl = 4'd4;
         2'd2:    lvl = 4'd8;
         default: lvl = 4'd14;
      endcase
      return lvl;
   endfunction

endpackage

// File: sv/uart16_rxq.sv
// Receive FIFO storage: one write port and one registered read port at the next head pointer.
// Depends on uart16_pkg for the FIFO geometry.
module uart16_rxq
   import uart16_pkg::*;
(
   input  logic       clock,
   input  logic       wr_en,
   input  rx_ptr_type wr_addr,
   input  logic [7:0] wr_data,
   input  rx_ptr_type rd_addr,
   output logic [7:0] rd_data
);

   logic [7:0] store_ff [RX_FIFO_DEPTH];
   logic [7:0] rd_data_ff;

   // Byte storage; contents are only read once written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read of the entry that will be at the head; a byte written there in the
   // same cycle is passed straight through.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/uart_16550_register_model.sv
// Top level of the 16550-style UART register block: register file, receive path and timeout.
// Depends on uart16_pkg and uart16_rxq.
//
//   channel  ports   direction  contents
//   req      req_*   in         func, reg_offset, two_byte_access, write_data, rx_byte
//   rsp      rsp_*   out        read_data, tx_valid, tx_byte, irq, rx_credit
//
// For each transfer the next register state and the result are computed together and
// stored at the accepting edge, so one item per cycle is sustained while rsp_ready is high.
// The result waits in an output register; a new transfer is taken whenever that register
// is empty or being emptied in the same cycle. Reset restores the power-on register values.
module uart_16550_register_model
   import uart16_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [2:0]  req_reg_offset,
   input  logic        req_two_byte_access,
   input  logic [15:0] req_write_data,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_irq,
   output logic [4:0]  rsp_rx_credit
);

   logic [15:0]          dl_ff, dl_in;
   logic [7:0]           rbr_ff, rbr_in;
   logic [3:0]           ier_ff, ier_in;
   logic [7:0]           iir_ff, iir_in;
   logic [7:0]           lcr_ff, lcr_in;
   logic [4:0]           mcr_ff, mcr_in;
   logic [7:0]           lsr_ff, lsr_in;
   logic [7:0]           msr_ff, msr_in;
   logic [7:0]           scr_ff, scr_in;
   logic [7:0]           fcr_ff, fcr_in;
   logic [3:0]           trig_ff, trig_in;
   logic                 thr_pend_ff, thr_pend_in;
   logic                 tmo_pend_ff, tmo_pend_in;
   rx_ptr_type           head_ff, head_in;
   rx_cnt_type           cnt_ff, cnt_in;
   logic [TIMEOUT_W-1:0] tmo_cnt_ff, tmo_cnt_in;
   logic                 tmo_arm_ff, tmo_arm_in;

   logic                 rsp_valid_ff;
   logic [7:0]           rd_data_ff, rd_data_in;
   logic                 tx_valid_ff, tx_valid_in;
   logic [7:0]           tx_byte_ff, tx_byte_in;
   logic                 irq_ff;
   logic [4:0]           credit_ff, credit_in;

   logic                 take;
   logic                 q_wr_en;
   rx_ptr_type           q_wr_addr;
   logic [7:0]           q_wr_data;
   logic [7:0]           q_rd_data;
   rx_ptr_type           head_next;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   // The FIFO read port looks at the head pointer as it will be after this edge.
   assign head_next = take ? head_in : head_ff;

   uart16_rxq u_rxq (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (q_wr_data),
      .rd_addr (head_next),
      .rd_data (q_rd_data)
   );

   // Next register state and result for the offered transfer.
   always_comb begin
      logic [7:0] lo;
      logic [7:0] fv;
      logic [3:0] changed;
      logic       rx_now;
      logic [7:0] rx_val;

      dl_in       = dl_ff;
      rbr_in      = rbr_ff;
      ier_in      = ier_ff;
      iir_in      = iir_ff;
      lcr_in      = lcr_ff;
      mcr_in      = mcr_ff;
      lsr_in      = lsr_ff;
      msr_in      = msr_ff;
      scr_in      = scr_ff;
      fcr_in      = fcr_ff;
      trig_in     = trig_ff;
      thr_pend_in = thr_pend_ff;
      tmo_pend_in = tmo_pend_ff;
      head_in     = head_ff;
      cnt_in      = cnt_ff;
      tmo_cnt_in  = tmo_cnt_ff;
      tmo_arm_in  = tmo_arm_ff;
      rd_data_in  = 8'd0;
      tx_valid_in = 1'b0;
      tx_byte_in  = 8'd0;
      q_wr_en     = 1'b0;
      q_wr_addr   = head_ff + cnt_ff[RX_PTR_W-1:0];
      q_wr_data   = 8'd0;
      lo          = req_write_data[7:0];
      fv          = 8'd0;
      changed     = 4'd0;
      rx_now      = 1'b0;
      rx_val      = req_rx_byte;

      case (req_func)
         FUNC_READ: begin
            case (req_reg_offset)
               OFF_RBR: begin
                  if (lcr_ff[7]) begin
                     rd_data_in = dl_ff[7:0];
                  end else begin
                     if (fcr_ff[0]) begin
                        if (cnt_ff != '0) begin
                           rd_data_in = q_rd_data;
                           head_in    = head_ff + 1'b1;
                           cnt_in     = cnt_ff - 1'b1;
                        end
                        if (cnt_in == '0) begin
                           lsr_in = lsr_ff & ~8'h11;
                        end else begin
                           tmo_cnt_in = timeout_reload(lcr_ff, dl_ff);
                           tmo_arm_in = 1'b1;
                        end
                        tmo_pend_in = 1'b0;
                     end else begin
                        rd_data_in = rbr_ff;
                        lsr_in     = lsr_ff & ~8'h11;
                     end
                     iir_in = irq_ident(iir_ff, ier_ff, lsr_in, tmo_pend_in, fcr_ff[0],
                                        cnt_in, trig_ff, thr_pend_ff, msr_ff);
                  end
               end
               OFF_IER: rd_data_in = lcr_ff[7] ? dl_ff[15:8] : {4'd0, ier_ff};
               OFF_IIR: begin
                  rd_data_in = iir_ff;
                  if (iir_ff[3:1] == 3'b001) begin
                     thr_pend_in = 1'b0;
                     iir_in = irq_ident(iir_ff, ier_ff, lsr_ff, tmo_pend_ff, fcr_ff[0],
                                        cnt_ff, trig_ff, 1'b0, msr_ff);
                  end
               end
               OFF_LCR: rd_data_in = lcr_ff;
               OFF_MCR: rd_data_in = {3'd0, mcr_ff};
               OFF_LSR: begin
                  rd_data_in = lsr_ff;
                  if (lsr_ff[1] || lsr_ff[4]) begin
                     lsr_in = lsr_ff & ~8'h12;
                     iir_in = irq_ident(iir_ff, ier_ff, lsr_in, tmo_pend_ff, fcr_ff[0],
                                        cnt_ff, trig_ff, thr_pend_ff, msr_ff);
                  end
               end
               OFF_MSR: begin
                  if (mcr_ff[4]) begin
                     // Loopback: modem outputs appear on the modem inputs.
                     rd_data_in = {mcr_ff[3:2], mcr_ff[0], mcr_ff[1], 4'd0};
                  end else begin
                     rd_data_in = msr_ff;
                     if (msr_ff[3:0] != 4'd0) begin
                        msr_in = {msr_ff[7:4], 4'd0};
                        iir_in = irq_ident(iir_ff, ier_ff, lsr_ff, tmo_pend_ff, fcr_ff[0],
                                           cnt_ff, trig_ff, thr_pend_ff, msr_in);
                     end
                  end
               end
               default: rd_data_in = scr_ff;
            endcase
         end
         FUNC_WRITE: begin
            case (req_reg_offset)
               OFF_RBR: begin
                  if (lcr_ff[7]) begin
                     dl_in = req_two_byte_access ? req_write_data : {dl_ff[15:8], lo};
                  end else begin
                     // The byte leaves at once, so THR is empty again straight away.
                     lsr_in      = lsr_ff | 8'h20;
                     thr_pend_in = 1'b1;
                     if (mcr_ff[4]) begin
                        rx_now = 1'b1;
                        rx_val = lo;
                     end else begin
                        tx_valid_in = 1'b1;
                        tx_byte_in  = lo;
                     end
                     iir_in = irq_ident(iir_ff, ier_ff, lsr_in, tmo_pend_ff, fcr_ff[0],
                                        cnt_ff, trig_ff, 1'b1, msr_ff);
                  end
               end
               OFF_IER: begin
                  if (lcr_ff[7]) begin
                     dl_in = {lo, dl_ff[7:0]};
                  end else begin
                     changed = ier_ff ^ lo[3:0];
                     ier_in  = lo[3:0];
                     if (changed[1]) begin
                        thr_pend_in = lo[1] && lsr_ff[5];
                     end
                     if (changed != 4'd0) begin
                        iir_in = irq_ident(iir_ff, ier_in, lsr_ff, tmo_pend_ff, fcr_ff[0],
                                           cnt_ff, trig_ff, thr_pend_in, msr_ff);
                     end
                  end
               end
               OFF_IIR: begin
                  fv = lo;
                  if (lo[0] != fcr_ff[0]) begin
                     fv = fv | 8'h06;
                  end
                  if (fv[1]) begin
                     lsr_in      = lsr_ff & ~8'h11;
                     tmo_arm_in  = 1'b0;
                     tmo_pend_in = 1'b0;
                     head_in     = '0;
                     cnt_in      = '0;
                  end
                  if (fv[2]) begin
                     lsr_in      = lsr_in | 8'h20;
                     thr_pend_in = 1'b1;
                  end
                  fcr_in = fv & FCR_MASK;
                  if (fcr_in[0]) begin
                     iir_in  = iir_ff | 8'hC0;
                     trig_in = trigger_level(fcr_in[7:6]);
                  end else begin
                     iir_in  = iir_ff & ~8'hC0;
                  end
                  iir_in = irq_ident(iir_in, ier_ff, lsr_in, tmo_pend_in, fcr_in[0],
                                     cnt_in, trig_in, thr_pend_in, msr_ff);
               end
               OFF_LCR: lcr_in = lo;
               OFF_MCR: mcr_in = lo[4:0];
               OFF_SCR: scr_in = lo;
               default: ;
            endcase
         end
         FUNC_RXB: rx_now = 1'b1;
         default: begin
            // Baud tick: run down the receive timeout.
            if (tmo_arm_ff) begin
               if (tmo_cnt_ff != '0) begin
                  tmo_cnt_in = tmo_cnt_ff - 1'b1;
               end
               if (tmo_cnt_in == '0) begin
                  tmo_arm_in = 1'b0;
                  if (cnt_ff != '0) begin
                     tmo_pend_in = 1'b1;
                     iir_in = irq_ident(iir_ff, ier_ff, lsr_ff, 1'b1, fcr_ff[0],
                                        cnt_ff, trig_ff, thr_pend_ff, msr_ff);
                  end
               end
            end
         end
      endcase

      // Receive path, fed by the line or by a loopback THR write.
      if (rx_now) begin
         if (fcr_ff[0]) begin
            if (cnt_ff < rx_cnt_type'(RX_FIFO_DEPTH)) begin
               q_wr_en   = 1'b1;
               q_wr_data = rx_val;
               cnt_in    = cnt_ff + 1'b1;
            end else begin
               lsr_in = lsr_in | 8'h02;
            end
            lsr_in     = lsr_in | 8'h01;
            tmo_cnt_in = timeout_reload(lcr_ff, dl_ff);
            tmo_arm_in = 1'b1;
         end else begin
            if (lsr_in[0]) begin
               lsr_in = lsr_in | 8'h02;
            end
            rbr_in = rx_val;
            lsr_in = lsr_in | 8'h01;
         end
         iir_in = irq_ident(iir_in, ier_ff, lsr_in, tmo_pend_ff, fcr_ff[0],
                            cnt_in, trig_ff, thr_pend_in, msr_ff);
      end

      // A THR write leaves the transmitter empty.
      if (req_func == FUNC_WRITE && req_reg_offset == OFF_RBR && !lcr_ff[7]) begin
         lsr_in = lsr_in | 8'h40;
      end

      // Receive credit after the transfer.
      if (fcr_in[0]) begin
         if (cnt_in < rx_cnt_type'(RX_FIFO_DEPTH)) begin
            credit_in = (cnt_in <= rx_cnt_type'(trig_in))
                        ? 5'(rx_cnt_type'(trig_in) - cnt_in) : 5'd1;
         end else begin
            credit_in = 5'd0;
         end
      end else begin
         credit_in = lsr_in[0] ? 5'd0 : 5'd1;
      end
   end

   // Register state, updated on each accepted transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         dl_ff       <= 16'h000C;
         rbr_ff      <= 8'h00;
         ier_ff      <= 4'h0;
         iir_ff      <= 8'h01;
         lcr_ff      <= 8'h00;
         mcr_ff      <= 5'h08;
         lsr_ff      <= 8'h60;
         msr_ff      <= 8'hB0;
         scr_ff      <= 8'h00;
         fcr_ff      <= 8'h00;
         trig_ff     <= 4'h0;
         thr_pend_ff <= 1'b0;
         tmo_pend_ff <= 1'b0;
         head_ff     <= '0;
         cnt_ff      <= '0;
         tmo_cnt_ff  <= '0;
         tmo_arm_ff  <= 1'b0;
      end else if (take) begin
         dl_ff       <= dl_in;
         rbr_ff      <= rbr_in;
         ier_ff      <= ier_in;
         iir_ff      <= iir_in;
         lcr_ff      <= lcr_in;
         mcr_ff      <= mcr_in;
         lsr_ff      <= lsr_in;
         msr_ff      <= msr_in;
         scr_ff      <= scr_in;
         fcr_ff      <= fcr_in;
         trig_ff     <= trig_in;
         thr_pend_ff <= thr_pend_in;
         tmo_pend_ff <= tmo_pend_in;
         head_ff     <= head_in;
         cnt_ff      <= cnt_in;
         tmo_cnt_ff  <= tmo_cnt_in;
         tmo_arm_ff  <= tmo_arm_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rd_data_ff  <= rd_data_in;
         tx_valid_ff <= tx_valid_in;
         tx_byte_ff  <= tx_byte_in;
         irq_ff      <= (iir_in[3:0] != IID_NONE);
         credit_ff   <= credit_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rd_data_ff;
   assign rsp_tx_valid  = tx_valid_ff;
   assign rsp_tx_byte   = tx_byte_ff;
   assign rsp_irq       = irq_ff;
   assign rsp_rx_credit = credit_ff;

endmodule
